// ===== sv/olpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpf_pkg
// Shared constants, types and the arctangent table for the line pair finder.
// ----------------------------------------------------------------------------
package olpf_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int RESULT_CAP   = 64;
  localparam int RES_W        = $clog2(RESULT_CAP + 1);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;
  localparam int ZW           = 16;
  localparam int ANG_W        = 15;
  localparam int SEG_W        = 64;
  localparam logic [ANG_W-1:0] ANG_QUARTER = 15'd16384;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_TOL    = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [14:0] OFFSET_RST = 15'd0;
  localparam logic [15:0] TOL_RST    = 16'd910;
  localparam logic [15:0] RADIUS_RST = 16'd25;

  typedef struct packed {
    logic load;
    logic iter;
    logic classify;
    logic read;
    logic mul_start;
    logic mul_end;
    logic adv;
    logic emit;
    logic flush;
  } olpf_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic last_seg;
    logic empty;
    logic scan_last;
    logic hit;
    logic cap_reached;
    logic out_free;
  } olpf_sts_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] k);
    logic [ZW-1:0] r;
    case (k)
      4'd0:    r = 16'd8192;
      4'd1:    r = 16'd4836;
      4'd2:    r = 16'd2555;
      4'd3:    r = 16'd1297;
      4'd4:    r = 16'd651;
      4'd5:    r = 16'd326;
      4'd6:    r = 16'd163;
      4'd7:    r = 16'd81;
      4'd8:    r = 16'd41;
      4'd9:    r = 16'd20;
      4'd10:   r = 16'd10;
      4'd11:   r = 16'd5;
      4'd12:   r = 16'd3;
      4'd13:   r = 16'd1;
      4'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/olpf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpf_ctrl
// Sequencer for angle computation, classification and the pair scan.
// ----------------------------------------------------------------------------
module olpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olpf_pkg::olpf_sts_t sts_i,
  output olpf_pkg::olpf_cmd_t cmd_o
);
  import olpf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CORD  = 4'd1;
  localparam logic [3:0] S_CLS   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_MS    = 4'd5;
  localparam logic [3:0] S_ME    = 4'd6;
  localparam logic [3:0] S_EV    = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CORD;
        end
      end
      S_CORD: begin
        cmd_o.iter = 1'b1;
        if (sts_i.cordic_done) begin
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        cmd_o.classify = 1'b1;
        state_d = sts_i.last_seg ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        state_d = sts_i.empty ? S_FLUSH : S_RD;
      end
      S_RD: begin
        cmd_o.read = 1'b1;
        state_d    = S_MS;
      end
      S_MS: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_ME;
      end
      S_ME: begin
        cmd_o.mul_end = 1'b1;
        state_d       = S_EV;
      end
      S_EV: begin
        if (sts_i.hit) begin
          state_d = S_EMIT;
        end else if (sts_i.scan_last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.cap_reached || sts_i.scan_last) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/olpf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpf_dp
// CORDIC angle unit, segment stores, join test and result register.
// ----------------------------------------------------------------------------
module olpf_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olpf_pkg::olpf_cmd_t   cmd_i,
  output olpf_pkg::olpf_sts_t   sts_o,
  input  logic [14:0]           angle_offset_i,
  input  logic [15:0]           angle_tolerance_i,
  input  logic [15:0]           join_radius_sq_i,
  input  logic [15:0]           x_start_i,
  input  logic [15:0]           y_start_i,
  input  logic [15:0]           x_end_i,
  input  logic [15:0]           y_end_i,
  input  logic                  last_segment_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_hor_o,
  output logic [63:0]           out_ver_o,
  output logic                  out_pair_valid_o,
  output logic                  out_overflow_o,
  output logic                  out_last_o
);
  import olpf_pkg::*;

  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [STEP_W-1:0]    k_q;
  logic                 ang_zero_q, ang_ninety_q, last_q;
  logic [SEG_W-1:0]     seg_q;

  logic [SEG_W-1:0] hor_mem [MAX_SEGMENTS];
  logic [SEG_W-1:0] ver_mem [MAX_SEGMENTS];
  logic [CNT_W-1:0] hor_cnt_q, ver_cnt_q;
  logic             dropped_q;

  logic [IDX_W-1:0] i_q, j_q;
  logic [SEG_W-1:0] rd_h_q, rd_v_q;
  logic [CW-1:0]    pa_q, pb_q;
  logic             near_s_q;
  logic [RES_W-1:0] n_q;
  logic [SEG_W-1:0] pend_h_q, pend_v_q;
  logic             pend_ok_q;

  logic [SEG_W-1:0] out_h_q, out_v_q;
  logic             out_valid_q, out_pv_q, out_ov_q, out_last_q;

  logic signed [16:0]   dx, dy, dxa, dya;
  logic                 neg;
  logic signed [CW-1:0] xs, ys;
  logic [ANG_W-1:0]     ang;
  logic signed [17:0]   dh, dv;
  logic [17:0]          dh_abs, dv_abs;
  logic                 is_h, is_v;
  logic signed [16:0]   ddx_s, ddy_s, ddx_e, ddy_e;
  logic [15:0]          ax_s, ay_s, ax_e, ay_e;
  logic [CW:0]          sum, lim;

  assign dx  = $signed({1'b0, x_end_i}) - $signed({1'b0, x_start_i});
  assign dy  = $signed({1'b0, y_end_i}) - $signed({1'b0, y_start_i});
  assign neg = dx[16];
  assign dxa = neg ? -dx : dx;
  assign dya = neg ? -dy : dy;

  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;

  assign ang = ang_zero_q ? '0 : (ang_ninety_q ? ANG_QUARTER : z_q[ANG_W-1:0]);
  assign dh  = $signed({3'b0, angle_offset_i}) - $signed({3'b0, ang});
  assign dv  = $signed({3'b0, angle_offset_i}) + $signed({3'b0, ANG_QUARTER})
             - $signed({3'b0, ang});
  assign dh_abs = dh[17] ? 18'(-dh) : 18'(dh);
  assign dv_abs = dv[17] ? 18'(-dv) : 18'(dv);
  assign is_h = dh_abs <= {2'b0, angle_tolerance_i};
  assign is_v = !is_h && (dv_abs <= {2'b0, angle_tolerance_i});

  assign ddx_s = $signed({1'b0, rd_h_q[15:0]})  - $signed({1'b0, rd_v_q[15:0]});
  assign ddy_s = $signed({1'b0, rd_h_q[31:16]}) - $signed({1'b0, rd_v_q[31:16]});
  assign ddx_e = $signed({1'b0, rd_h_q[15:0]})  - $signed({1'b0, rd_v_q[47:32]});
  assign ddy_e = $signed({1'b0, rd_h_q[31:16]}) - $signed({1'b0, rd_v_q[63:48]});
  assign ax_s  = ddx_s[16] ? 16'(-ddx_s) : ddx_s[15:0];
  assign ay_s  = ddy_s[16] ? 16'(-ddy_s) : ddy_s[15:0];
  assign ax_e  = ddx_e[16] ? 16'(-ddx_e) : ddx_e[15:0];
  assign ay_e  = ddy_e[16] ? 16'(-ddy_e) : ddy_e[15:0];
  assign sum   = {1'b0, pa_q} + {1'b0, pb_q};
  assign lim   = {{(CW - 23){1'b0}}, join_radius_sq_i, 8'd0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q          <= $signed({{(CW - 17){dxa[16]}}, dxa}) <<< 14;
      y_q          <= $signed({{(CW - 17){dya[16]}}, dya}) <<< 14;
      z_q          <= '0;
      seg_q        <= {y_end_i, x_end_i, y_start_i, x_start_i};
      ang_zero_q   <= (dy == 17'sd0);
      ang_ninety_q <= (dx == 17'sd0);
      last_q       <= last_segment_i;
    end else if (cmd_i.iter) begin
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + $signed(atan_lut(k_q));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - $signed(atan_lut(k_q));
      end
    end
    if (cmd_i.classify && is_h && (hor_cnt_q < CNT_W'(MAX_SEGMENTS))) begin
      hor_mem[hor_cnt_q[IDX_W-1:0]] <= seg_q;
    end
    if (cmd_i.classify && is_v && (ver_cnt_q < CNT_W'(MAX_SEGMENTS))) begin
      ver_mem[ver_cnt_q[IDX_W-1:0]] <= seg_q;
    end
    if (cmd_i.read) begin
      rd_h_q <= hor_mem[i_q];
      rd_v_q <= ver_mem[j_q];
    end
    if (cmd_i.mul_start) begin
      pa_q <= CW'({16'd0, ax_s} * {16'd0, ax_s});
      pb_q <= CW'({16'd0, ay_s} * {16'd0, ay_s});
    end else if (cmd_i.mul_end) begin
      near_s_q <= (sum <= lim);
      pa_q     <= CW'({16'd0, ax_e} * {16'd0, ax_e});
      pb_q     <= CW'({16'd0, ay_e} * {16'd0, ay_e});
    end
    if (cmd_i.emit) begin
      pend_h_q <= rd_h_q;
      pend_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      hor_cnt_q <= '0;
      ver_cnt_q <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      pend_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        k_q <= '0;
      end else if (cmd_i.iter) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.classify) begin
        i_q <= '0;
        j_q <= '0;
        if (is_h) begin
          if (hor_cnt_q < CNT_W'(MAX_SEGMENTS)) begin
            hor_cnt_q <= hor_cnt_q + 1'b1;
          end else begin
            dropped_q <= 1'b1;
          end
        end
        if (is_v) begin
          if (ver_cnt_q < CNT_W'(MAX_SEGMENTS)) begin
            ver_cnt_q <= ver_cnt_q + 1'b1;
          end else begin
            dropped_q <= 1'b1;
          end
        end
      end
      if (cmd_i.adv) begin
        if ({1'b0, j_q} + 1'b1 == CNT_W'(ver_cnt_q)) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        pend_ok_q <= 1'b1;
        n_q       <= n_q + 1'b1;
      end
      if (cmd_i.flush) begin
        hor_cnt_q <= '0;
        ver_cnt_q <= '0;
        dropped_q <= 1'b0;
        pend_ok_q <= 1'b0;
        n_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_h_q    <= pend_h_q;
      out_v_q    <= pend_v_q;
      out_pv_q   <= 1'b1;
      out_ov_q   <= dropped_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.flush) begin
      out_h_q    <= pend_ok_q ? pend_h_q : '0;
      out_v_q    <= pend_ok_q ? pend_v_q : '0;
      out_pv_q   <= pend_ok_q;
      out_ov_q   <= dropped_q;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.emit && pend_ok_q) || cmd_i.flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.cordic_done = (k_q == STEP_W'(CORDIC_STEPS - 1));
  assign sts_o.last_seg    = last_q;
  assign sts_o.empty       = (hor_cnt_q == '0) || (ver_cnt_q == '0);
  assign sts_o.scan_last   = ({1'b0, i_q} + 1'b1 == CNT_W'(hor_cnt_q))
                          && ({1'b0, j_q} + 1'b1 == CNT_W'(ver_cnt_q));
  assign sts_o.hit         = near_s_q || (sum <= lim);
  assign sts_o.cap_reached = (n_q == RES_W'(RESULT_CAP - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_hor_o        = out_h_q;
  assign out_ver_o        = out_v_q;
  assign out_pair_valid_o = out_pv_q;
  assign out_overflow_o   = out_ov_q;
  assign out_last_o       = out_last_q;

endmodule

// ===== sv/orthogonal_line_pair_finder.sv =====
`timescale 1ns / 1ps
// An item is taken only once the previous one is through: a load, then 16
// CORDIC iterations in the angle unit, then a classify step. A last item then
// scans the stored pairs, up to the result cap, through the shared squaring
// unit, plus an emit step per result that waits while the output is stalled.
// Reset is asynchronous; it clears counts, flags, settings and the sequencer.
// ----------------------------------------------------------------------------
// orthogonal_line_pair_finder
// Classifies segments by angle and pairs horizontals with nearby verticals.
// ----------------------------------------------------------------------------
module orthogonal_line_pair_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] x_start_i,
  input  logic [15:0] y_start_i,
  input  logic [15:0] x_end_i,
  input  logic [15:0] y_end_i,
  input  logic        last_segment_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] hor_x_start_o,
  output logic [15:0] hor_y_start_o,
  output logic [15:0] hor_x_end_o,
  output logic [15:0] hor_y_end_o,
  output logic [15:0] ver_x_start_o,
  output logic [15:0] ver_y_start_o,
  output logic [15:0] ver_x_end_o,
  output logic [15:0] ver_y_end_o,
  output logic        pair_valid_o,
  output logic        overflow_o,
  output logic        last_result_o
);
  import olpf_pkg::*;

  logic [14:0] offset_q;
  logic [15:0] tol_q, radius_q;
  olpf_cmd_t   cmd;
  olpf_sts_t   sts;
  logic [63:0] out_hor, out_ver;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      tol_q    <= TOL_RST;
      radius_q <= RADIUS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_OFFSET: offset_q <= pwdata[14:0];
        REG_TOL:    tol_q    <= pwdata[15:0];
        REG_RADIUS: radius_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET: prdata = {17'd0, offset_q};
      REG_TOL:    prdata = {16'd0, tol_q};
      REG_RADIUS: prdata = {16'd0, radius_q};
      default:    prdata = '0;
    endcase
  end

  olpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olpf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .angle_offset_i    (offset_q),
    .angle_tolerance_i (tol_q),
    .join_radius_sq_i  (radius_q),
    .x_start_i         (x_start_i),
    .y_start_i         (y_start_i),
    .x_end_i           (x_end_i),
    .y_end_i           (y_end_i),
    .last_segment_i    (last_segment_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_hor_o         (out_hor),
    .out_ver_o         (out_ver),
    .out_pair_valid_o  (pair_valid_o),
    .out_overflow_o    (overflow_o),
    .out_last_o        (last_result_o)
  );

  assign hor_x_start_o = out_hor[15:0];
  assign hor_y_start_o = out_hor[31:16];
  assign hor_x_end_o   = out_hor[47:32];
  assign hor_y_end_o   = out_hor[63:48];
  assign ver_x_start_o = out_ver[15:0];
  assign ver_y_start_o = out_ver[31:16];
  assign ver_x_end_o   = out_ver[47:32];
  assign ver_y_end_o   = out_ver[63:48];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while the block is busy");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> last_result_o)
    else $error("empty result is not marked last");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> (hor_x_start_o == '0) && (ver_y_end_o == '0))
    else $error("empty result carries coordinates");

  a_no_input_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> !in_ready_o)
    else $error("input taken during the pair scan");

endmodule

// ===== test/tb_orthogonal_line_pair_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orthogonal_line_pair_finder
// Drives line segments through the pair finder under several register
// settings and handshake pressures. A scoreboard classifies each accepted
// segment by its CORDIC angle, builds the expected pair list on the last
// segment of a set, and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_orthogonal_line_pair_finder;
  import olpf_pkg::*;

  typedef struct packed {
    logic [15:0] xs, ys, xe, ye;
  } seg_t;

  typedef struct packed {
    seg_t hor;
    seg_t ver;
    logic pair_valid;
    logic overflow;
    logic last_result;
  } pair_t;

  class pair_scoreboard;
    seg_t   hor_segs[$];
    seg_t   ver_segs[$];
    logic   dropped;
    logic [14:0] offset;
    logic [15:0] tol;
    logic [15:0] radius_sq;
    pair_t  pending[$];
    int     errors;
    int     checked;
    int     sets;

    function void clear_config();
      offset = OFFSET_RST;
      tol = TOL_RST;
      radius_sq = RADIUS_RST;
      dropped = 1'b0;
      errors = 0;
      checked = 0;
      sets = 0;
    endfunction

    function longint fshift(longint v, int k);
      return v >>> k;
    endfunction

    function int seg_angle(longint dx, longint dy);
      longint x, y, xt, yt;
      int z;
      z = 0;
      if (dy == 0) return 0;
      if (dx == 0) return 16384;
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
      end
      x = dx * 16384;
      y = dy * 16384;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xt = fshift(x, i);
        yt = fshift(y, i);
        if (y >= 0) begin
          x += yt; y -= xt; z += int'(atan_lut(i[3:0]));
        end else begin
          x -= yt; y += xt; z -= int'(atan_lut(i[3:0]));
        end
      end
      return z & 32'h7fff;
    endfunction

    function bit near(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                      logic [15:0] by);
      longint ddx, ddy;
      ddx = longint'(ax) - longint'(bx);
      ddy = longint'(ay) - longint'(by);
      return ddx * ddx + ddy * ddy <= longint'(radius_sq) * 256;
    endfunction

    function void note_segment(seg_t s, logic last);
      longint ang, dh, dv;
      pair_t r;
      ang = seg_angle(longint'(s.xe) - longint'(s.xs), longint'(s.ye) - longint'(s.ys));
      dh = longint'(offset) - ang;
      dv = longint'(offset) + 16384 - ang;
      if (dh < 0) dh = -dh;
      if (dv < 0) dv = -dv;
      if (dh <= longint'(tol)) begin
        if (hor_segs.size() < MAX_SEGMENTS) hor_segs = {hor_segs, s};
        else dropped = 1'b1;
      end else if (dv <= longint'(tol)) begin
        if (ver_segs.size() < MAX_SEGMENTS) ver_segs = {ver_segs, s};
        else dropped = 1'b1;
      end
      if (!last) return;
      sets++;
      begin
        int n;
        n = 0;
        foreach (hor_segs[i]) begin
          foreach (ver_segs[j]) begin
            if (n < RESULT_CAP && (near(hor_segs[i].xs, hor_segs[i].ys, ver_segs[j].xs,
                ver_segs[j].ys) || near(hor_segs[i].xs, hor_segs[i].ys,
                ver_segs[j].xe, ver_segs[j].ye))) begin
              r.hor = hor_segs[i];
              r.ver = ver_segs[j];
              r.pair_valid = 1'b1;
              r.overflow = dropped;
              r.last_result = (n == RESULT_CAP - 1);
              pending = {pending, r};
              n++;
            end
          end
        end
        if (n == 0) begin
          r = '0;
          r.overflow = dropped;
          r.last_result = 1'b1;
          pending = {pending, r};
        end else begin
          pending[pending.size()-1].last_result = 1'b1;
        end
      end
      hor_segs.delete();
      ver_segs.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(pair_t got);
      pair_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hor != exp.hor) begin
        $display("%0t: hor expected %h actual %h", $time, exp.hor, got.hor);
        errors++;
      end
      if (got.ver != exp.ver) begin
        $display("%0t: ver expected %h actual %h", $time, exp.ver, got.ver);
        errors++;
      end
      if (got.pair_valid != exp.pair_valid) begin
        $display("%0t: pair_valid expected %b actual %b", $time, exp.pair_valid,
                 got.pair_valid);
        errors++;
      end
      if (got.overflow != exp.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, exp.overflow, got.overflow);
        errors++;
      end
      if (got.last_result != exp.last_result) begin
        $display("%0t: last_result expected %b actual %b", $time, exp.last_result,
                 got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] x_start_i = '0, y_start_i = '0, x_end_i = '0, y_end_i = '0;
  logic        last_segment_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] hor_x_start_o, hor_y_start_o, hor_x_end_o, hor_y_end_o;
  logic [15:0] ver_x_start_o, ver_y_start_o, ver_x_end_o, ver_y_end_o;
  logic        pair_valid_o, overflow_o, last_result_o;

  pair_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycles;
  int  items_sent;

  localparam longint CYCLE_LIMIT = 2000000;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  orthogonal_line_pair_finder i_dut (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_segment({x_start_i, y_start_i, x_end_i, y_end_i}, last_segment_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({hor_x_start_o, hor_y_start_o, hor_x_end_o, hor_y_end_o,
                       ver_x_start_o, ver_y_start_o, ver_x_end_o, ver_y_end_o,
                       pair_valid_o, overflow_o, last_result_o});
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_OFFSET) sb.offset = val[14:0];
    else if (idx == REG_TOL) sb.tol = val[15:0];
    else sb.radius_sq = val[15:0];
  endtask

  task automatic send_segment(seg_t s, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    {x_start_i, y_start_i, x_end_i, y_end_i} <= s;
    last_segment_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Builds a segment near a corner point so that pairs are likely.
  function automatic seg_t make_seg(int cx, int cy, bit vert);
    seg_t s;
    int len, jit;
    len = $urandom_range(400, 16);
    jit = $urandom_range(6);
    s.xs = 16'(cx + $urandom_range(40));
    s.ys = 16'(cy + $urandom_range(40));
    if (vert) begin
      s.xe = 16'(int'(s.xs) + jit - 3);
      s.ye = 16'(int'(s.ys) + (($urandom_range(1)) ? len : -len));
    end else begin
      s.xe = 16'(int'(s.xs) + (($urandom_range(1)) ? len : -len));
      s.ye = 16'(int'(s.ys) + jit - 3);
    end
    if ($urandom_range(3) == 0) s = {s.xe, s.ye, s.xs, s.ys};
    return s;
  endfunction

  task automatic random_set(int nseg);
    int cx, cy, k;
    seg_t s;
    cx = $urandom_range(60000, 500);
    cy = $urandom_range(60000, 500);
    for (k = 0; k < nseg; k++) begin
      k = k;
      case ($urandom_range(9))
        0: s = seg_t'({$urandom, $urandom});
        1: s = {16'(16'hffff * $urandom_range(1)), 16'(16'hffff * $urandom_range(1)),
                16'(16'hffff * $urandom_range(1)), 16'(16'hffff * $urandom_range(1))};
        default: s = make_seg(cx, cy, $urandom_range(1));
      endcase
      send_segment(s, k == nseg - 1);
    end
  endtask

  task automatic random_phase(int nitems);
    int done_items;
    done_items = 0;
    while (done_items < nitems) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
      random_set(n);
      done_items += n;
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear_config();
    cycles = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero length, axis-aligned, both directions, field extremes.
    send_segment({16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
    send_segment({16'd100, 16'd100, 16'd300, 16'd100}, 1'b0);
    send_segment({16'd110, 16'd90, 16'd110, 16'd400}, 1'b0);
    send_segment({16'd500, 16'd120, 16'd100, 16'd120}, 1'b0);
    send_segment({16'd105, 16'd600, 16'd105, 16'd95}, 1'b0);
    send_segment({16'd0, 16'd0, 16'hffff, 16'hffff}, 1'b0);
    send_segment({16'hffff, 16'hffff, 16'd0, 16'd1}, 1'b0);
    send_segment({16'hffff, 16'd0, 16'd0, 16'hffff}, 1'b1);
    send_segment({16'd7, 16'd7, 16'd900, 16'd8}, 1'b1);
    drain();
    // Store overflow and the result cap: 17 horizontals and 17 verticals at one spot.
    for (int i = 0; i < 17; i++) send_segment({16'd1000, 16'd1000, 16'd1300, 16'd1000}, 1'b0);
    for (int i = 0; i < 17; i++) send_segment({16'd1000, 16'd1000, 16'd1000, 16'd800}, 1'b0);
    send_segment({16'd0, 16'd0, 16'd0, 16'd0}, 1'b1);
    drain();

    write_reg(REG_OFFSET, 32'd32767);
    write_reg(REG_TOL, 32'd32768);
    write_reg(REG_RADIUS, 32'd65535);
    send_segment({16'd3, 16'd4, 16'd1, 16'd9}, 1'b0);
    send_segment({16'hffff, 16'd0, 16'd0, 16'd1}, 1'b1);
    drain();
    write_reg(REG_OFFSET, 32'd0);
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_RADIUS, 32'd0);
    send_segment({16'd50, 16'd50, 16'd80, 16'd50}, 1'b0);
    send_segment({16'd50, 16'd50, 16'd50, 16'd10}, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_reg(REG_OFFSET, (ph == 3) ? 32'd16384 : $urandom_range(2000));
      write_reg(REG_TOL, (ph == 1) ? 32'd4000 : $urandom_range(2000, 200));
      write_reg(REG_RADIUS, $urandom_range(400, 1));
      random_phase(100);
    end
    drain();

    $display("Sent %0d segments in %0d sets; checked %0d results under varied settings.",
             items_sent, sb.sets, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
